// File: hw/rtl/pcgm_pkg.sv
package pcgm_pkg;

  localparam int CHANNEL_BITS_DEF  = 8;
  localparam int POS_FRAC_BITS_DEF = 16;

  localparam int DATA_BITS     = 64;
  localparam int ADDR_BITS     = 6;
  localparam int MODE_BITS     = 3;
  localparam int REPEAT_BITS   = 8;
  localparam int NUM_STOPS     = 11;
  localparam int NUM_PAIR_REGS = 5;
  localparam int STOP_IDX_BITS = 4;
  localparam int SPAN_BITS     = 3;
  localparam int IP_BITS       = 6;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_THREE     = 3'd0,
    MODE_FOUR      = 3'd1,
    MODE_SEVEN     = 3'd2,
    MODE_ELEVEN    = 3'd3,
    MODE_REP_BLEND = 3'd4,
    MODE_REP_STEP  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_REPEAT     = 3'd1,
    REG_STOPS_1_2  = 3'd2,
    REG_STOPS_3_4  = 3'd3,
    REG_STOPS_5_6  = 3'd4,
    REG_STOPS_7_8  = 3'd5,
    REG_STOPS_9_10 = 3'd6,
    REG_STOP_11    = 3'd7
  } reg_idx_t;

  typedef logic [STOP_IDX_BITS-1:0] stop_idx_t;

  typedef struct packed {
    stop_idx_t             lo;
    stop_idx_t             hi;
    logic [SPAN_BITS-1:0]  span;
    logic                  blank;
  } seg_sel_t;

  // Segment boundaries of the eleven-stop ramp, in fortieths of the range.
  localparam logic [IP_BITS-1:0] SEG_START [NUM_STOPS] = '{
    6'd0, 6'd6, 6'd11, 6'd15, 6'd18, 6'd20, 6'd22, 6'd25, 6'd29, 6'd34, 6'd40
  };

  function automatic stop_idx_t seg_of(input logic [IP_BITS-1:0] ip);
    stop_idx_t seg;
    seg = '0;
    for (int i = 1; i < NUM_STOPS - 1; i++) begin
      if (ip >= SEG_START[i]) begin
        seg = seg + 1'b1;
      end
    end
    return seg;
  endfunction

endpackage

// File: hw/rtl/pcgm_regs.sv
module pcgm_regs #(
  parameter int CHANNEL_BITS = pcgm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcgm_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [pcgm_pkg::DATA_BITS-1:0]      pwdata,
  output logic [pcgm_pkg::DATA_BITS-1:0]      prdata,
  output pcgm_pkg::mode_t                     mode,
  output logic [pcgm_pkg::REPEAT_BITS-1:0]    repeat_count,
  output logic [pcgm_pkg::NUM_STOPS-1:0][2:0][CHANNEL_BITS-1:0] stops
);
  import pcgm_pkg::*;

  localparam int EXT_BITS  = 6 * CHANNEL_BITS;
  localparam int PAIR_BITS = (6 * CHANNEL_BITS > DATA_BITS) ? DATA_BITS : 6 * CHANNEL_BITS;
  localparam int LAST_BITS = (3 * CHANNEL_BITS > DATA_BITS) ? DATA_BITS : 3 * CHANNEL_BITS;

  logic [PAIR_BITS-1:0] pair [NUM_PAIR_REGS];
  logic [LAST_BITS-1:0] last_stop;
  logic [EXT_BITS-1:0]  pair_ext [NUM_PAIR_REGS];
  logic [EXT_BITS-1:0]  last_ext;
  logic                 wr;
  reg_idx_t             idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[ADDR_BITS-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_THREE;
      repeat_count <= REPEAT_BITS'(1);
      for (int i = 0; i < NUM_PAIR_REGS; i++) begin
        pair[i] <= '0;
      end
      last_stop    <= '0;
    end else if (wr) begin
      case (idx)
        REG_MODE:       mode         <= mode_t'(pwdata[MODE_BITS-1:0]);
        REG_REPEAT:     repeat_count <= pwdata[REPEAT_BITS-1:0];
        REG_STOPS_1_2:  pair[0]      <= pwdata[PAIR_BITS-1:0];
        REG_STOPS_3_4:  pair[1]      <= pwdata[PAIR_BITS-1:0];
        REG_STOPS_5_6:  pair[2]      <= pwdata[PAIR_BITS-1:0];
        REG_STOPS_7_8:  pair[3]      <= pwdata[PAIR_BITS-1:0];
        REG_STOPS_9_10: pair[4]      <= pwdata[PAIR_BITS-1:0];
        REG_STOP_11:    last_stop    <= pwdata[LAST_BITS-1:0];
        default:        mode         <= mode;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:       prdata = DATA_BITS'(mode);
      REG_REPEAT:     prdata = DATA_BITS'(repeat_count);
      REG_STOPS_1_2:  prdata = DATA_BITS'(pair[0]);
      REG_STOPS_3_4:  prdata = DATA_BITS'(pair[1]);
      REG_STOPS_5_6:  prdata = DATA_BITS'(pair[2]);
      REG_STOPS_7_8:  prdata = DATA_BITS'(pair[3]);
      REG_STOPS_9_10: prdata = DATA_BITS'(pair[4]);
      REG_STOP_11:    prdata = DATA_BITS'(last_stop);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_PAIR_REGS; i++) begin
      pair_ext[i] = EXT_BITS'(pair[i]);
    end
    last_ext = EXT_BITS'(last_stop);
  end

  // Channel bits that would lie above the register width read as zero.
  for (genvar s = 0; s < NUM_STOPS; s++) begin : g_stop
    for (genvar c = 0; c < 3; c++) begin : g_ch
      localparam int POS = (s % 2) * 3 * CHANNEL_BITS + c * CHANNEL_BITS;
      if (s < NUM_STOPS - 1) begin : g_pair
        assign stops[s][c] = pair_ext[s / 2][POS +: CHANNEL_BITS];
      end else begin : g_last
        assign stops[s][c] = last_ext[POS +: CHANNEL_BITS];
      end
    end
  end

endmodule

// File: hw/rtl/pcgm_locate.sv
module pcgm_locate #(
  parameter int POSITION_FRAC_BITS = pcgm_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pos_valid,
  output logic                                pos_ready,
  input  logic signed [POSITION_FRAC_BITS+1:0] position,
  input  pcgm_pkg::mode_t                     mode,
  input  logic [pcgm_pkg::REPEAT_BITS-1:0]    repeat_count,
  output logic                                sel_valid,
  input  logic                                sel_ready,
  output pcgm_pkg::seg_sel_t                  sel,
  output logic [POSITION_FRAC_BITS+2:0]       num
);
  import pcgm_pkg::*;

  localparam int F   = POSITION_FRAC_BITS;
  localparam int PW  = F + 2;
  localparam int NW  = F + 3;
  localparam int SW  = F + IP_BITS;
  localparam int RW  = REPEAT_BITS + 3;
  localparam int XW  = PW + RW;
  localparam int HW  = XW - F;
  localparam logic [HW-1:0] RECIP3     = HW'((2 ** HW) / 3);
  localparam logic [NW-1:0] HALF       = NW'(2 ** (F - 1));
  localparam logic [NW-1:0] THREE_HALF = NW'(3 * (2 ** (F - 1)));
  localparam logic [NW-1:0] FIVE_HALF  = NW'(5 * (2 ** (F - 1)));

  // Stage A: scaled position, range flags and distance from the center.
  logic                 a_valid, a_below, a_above;
  logic [SW-1:0]        a_scaled;
  logic [PW-1:0]        a_dist;
  logic [IP_BITS-1:0]   mult;
  logic signed [PW:0]   shifted;
  logic [SW-1:0]        scaled_next;
  logic [PW-1:0]        dist_next;

  // Stage B: segment choice for the fixed ramps, phase product for the cycle.
  logic                 b_valid, b_ready;
  seg_sel_t             b_sel, b_sel_next;
  logic [NW-1:0]        b_num, b_num_next;
  logic [XW-1:0]        b_x, x_next;
  logic [RW-1:0]        rc6;
  logic [IP_BITS-1:0]   ip;
  logic [F-1:0]         fr;
  stop_idx_t            seg, last_idx;
  logic [IP_BITS-1:0]   start;

  // Stage C: quotient estimate for the phase modulo three.
  logic                 c_valid, c_ready;
  seg_sel_t             c_sel;
  logic [NW-1:0]        c_num;
  logic [HW-1:0]        c_h, c_q;
  logic [F-1:0]         c_l;
  logic [2*HW-1:0]      prod3;

  // Stage D: phase within the cycle and the cycle's segment choice.
  logic                 d_ready;
  seg_sel_t             d_sel_next;
  logic [NW-1:0]        d_num_next;
  logic [HW-1:0]        rem;
  logic [2:0]           rem3;
  logic [NW-1:0]        phase;

  assign pos_ready = !a_valid || b_ready;
  assign b_ready   = !b_valid || c_ready;
  assign c_ready   = !c_valid || d_ready;
  assign d_ready   = !sel_valid || sel_ready;

  always_comb begin
    case (mode)
      MODE_THREE: mult = IP_BITS'(2);
      MODE_FOUR:  mult = IP_BITS'(3);
      MODE_SEVEN: mult = IP_BITS'(6);
      default:    mult = IP_BITS'(40);
    endcase
    scaled_next = SW'(position[F-1:0]) * SW'(mult);
    shifted     = $signed({position[PW-1], position}) - $signed((PW + 1)'(HALF));
    if (shifted[PW]) begin
      dist_next = PW'(-shifted);
    end else begin
      dist_next = PW'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pos_ready) begin
      a_valid <= pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_ready && pos_valid) begin
      a_below  <= position[PW-1];
      a_above  <= !position[PW-1] && (position[PW-2:F] != '0);
      a_scaled <= scaled_next;
      a_dist   <= dist_next;
    end
  end

  always_comb begin
    ip    = a_scaled[SW-1:F];
    fr    = a_scaled[F-1:0];
    rc6   = (RW'(repeat_count) << 2) + (RW'(repeat_count) << 1);
    x_next = XW'(rc6) * XW'(a_dist);
    seg   = seg_of(ip);
    start = SEG_START[seg];
    case (mode)
      MODE_THREE: last_idx = 4'd2;
      MODE_FOUR:  last_idx = 4'd3;
      MODE_SEVEN: last_idx = 4'd6;
      default:    last_idx = 4'd10;
    endcase
    b_sel_next = '{lo: '0, hi: '0, span: SPAN_BITS'(1), blank: 1'b0};
    b_num_next = '0;
    case (mode)
      MODE_THREE, MODE_FOUR, MODE_SEVEN, MODE_ELEVEN: begin
        if (a_below) begin
          b_sel_next.lo = '0;
          b_sel_next.hi = '0;
        end else if (a_above) begin
          b_sel_next.lo = last_idx;
          b_sel_next.hi = last_idx;
        end else if (mode == MODE_ELEVEN) begin
          b_sel_next.lo   = seg;
          b_sel_next.hi   = seg + 1'b1;
          b_sel_next.span = SPAN_BITS'(SEG_START[seg + 1'b1] - start);
          b_num_next      = {SPAN_BITS'(ip - start), fr};
        end else begin
          b_sel_next.lo = STOP_IDX_BITS'(ip);
          b_sel_next.hi = STOP_IDX_BITS'(ip) + 1'b1;
          b_num_next    = NW'(fr);
        end
      end
      MODE_REP_BLEND, MODE_REP_STEP: begin
        b_sel_next.blank = 1'b0;
      end
      default: begin
        b_sel_next.blank = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_sel <= b_sel_next;
      b_num <= b_num_next;
      b_x   <= x_next;
    end
  end

  assign prod3 = (2 * HW)'(b_x[XW-1:F]) * (2 * HW)'(RECIP3);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      c_sel <= b_sel;
      c_num <= b_num;
      c_h   <= b_x[XW-1:F];
      c_q   <= prod3[2*HW-1:HW];
      c_l   <= b_x[F-1:0];
    end
  end

  always_comb begin
    rem  = c_h - ((c_q << 1) + c_q);
    rem3 = rem[2:0];
    if (rem3 >= 3'd3) begin
      rem3 = rem3 - 3'd3;
    end
    phase      = NW'({rem3[1:0], c_l});
    d_sel_next = c_sel;
    d_num_next = c_num;
    case (mode)
      MODE_REP_BLEND: begin
        d_sel_next.span = SPAN_BITS'(1);
        if (phase < HALF) begin
          d_sel_next.lo = 4'd0;
          d_sel_next.hi = 4'd1;
          d_num_next    = phase + HALF;
        end else if (phase < THREE_HALF) begin
          d_sel_next.lo = 4'd1;
          d_sel_next.hi = 4'd2;
          d_num_next    = phase - HALF;
        end else if (phase < FIVE_HALF) begin
          d_sel_next.lo = 4'd2;
          d_sel_next.hi = 4'd0;
          d_num_next    = phase - THREE_HALF;
        end else begin
          d_sel_next.lo = 4'd0;
          d_sel_next.hi = 4'd1;
          d_num_next    = phase - FIVE_HALF;
        end
      end
      MODE_REP_STEP: begin
        d_sel_next.span = SPAN_BITS'(1);
        d_num_next      = '0;
        if (phase < HALF) begin
          d_sel_next.lo = 4'd0;
        end else if (phase < THREE_HALF) begin
          d_sel_next.lo = 4'd1;
        end else if (phase < FIVE_HALF) begin
          d_sel_next.lo = 4'd2;
        end else begin
          d_sel_next.lo = 4'd0;
        end
        d_sel_next.hi = d_sel_next.lo;
      end
      default: begin
        d_sel_next = c_sel;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (d_ready) begin
      sel_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      sel <= d_sel_next;
      num <= d_num_next;
    end
  end

endmodule

// File: hw/rtl/pcgm_blend.sv
module pcgm_blend #(
  parameter int CHANNEL_BITS       = pcgm_pkg::CHANNEL_BITS_DEF,
  parameter int POSITION_FRAC_BITS = pcgm_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sel_valid,
  output logic                          sel_ready,
  input  pcgm_pkg::seg_sel_t            sel,
  input  logic [POSITION_FRAC_BITS+2:0] num,
  input  logic [pcgm_pkg::NUM_STOPS-1:0][2:0][CHANNEL_BITS-1:0] stops,
  output logic                          color_valid,
  input  logic                          color_stall,
  output logic [CHANNEL_BITS-1:0]       red,
  output logic [CHANNEL_BITS-1:0]       green,
  output logic [CHANNEL_BITS-1:0]       blue
);
  import pcgm_pkg::*;

  localparam int F     = POSITION_FRAC_BITS;
  localparam int CB    = CHANNEL_BITS;
  localparam int NW    = F + 3;
  localparam int PRODW = NW + CB + 2;
  localparam int BASEW = CB + SPAN_BITS;
  localparam int QW    = CB + SPAN_BITS;
  localparam int MW    = QW + 1;
  localparam logic [MW-1:0] RECIP_1 = MW'(2 ** QW);
  localparam logic [MW-1:0] RECIP_2 = MW'((2 ** QW) / 2);
  localparam logic [MW-1:0] RECIP_3 = MW'((2 ** QW) / 3);
  localparam logic [MW-1:0] RECIP_4 = MW'((2 ** QW) / 4);
  localparam logic [MW-1:0] RECIP_5 = MW'((2 ** QW) / 5);
  localparam logic [MW-1:0] RECIP_6 = MW'((2 ** QW) / 6);

  // Stage E: stop fetch and the weighted difference.
  logic                    e_valid, f_ready;
  logic signed [PRODW-1:0] e_prod [3];
  logic [BASEW-1:0]        e_base [3];
  logic [SPAN_BITS-1:0]    e_span;
  logic                    e_blank;
  logic [CB-1:0]           lo_ch [3];
  logic [CB-1:0]           hi_ch [3];
  logic signed [CB:0]      diff [3];

  // Stage F: integer part of the blended value, scaled by the span.
  logic                    f_valid, g_ready;
  logic [QW-1:0]           f_q1 [3];
  logic [SPAN_BITS-1:0]    f_span;
  logic                    f_blank;
  logic signed [PRODW-1:0] sum [3];

  // Stage G: quotient estimate by the span's reciprocal.
  logic                    g_valid, h_ready;
  logic [QW-1:0]           g_q1 [3];
  logic [CB-1:0]           g_qest [3];
  logic [SPAN_BITS-1:0]    g_span;
  logic                    g_blank;
  logic [MW-1:0]           recip;
  logic [QW+MW-1:0]        prodm [3];

  // Stage H: one correction step, then the output register.
  logic [QW-1:0]           rem [3];
  logic [CB-1:0]           quot [3];
  logic [CB-1:0]           h_ch [3];

  assign sel_ready = !e_valid || f_ready;
  assign f_ready   = !f_valid || g_ready;
  assign g_ready   = !g_valid || h_ready;
  assign h_ready   = !color_valid || !color_stall;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lo_ch[c] = stops[sel.lo][c];
      hi_ch[c] = stops[sel.hi][c];
      diff[c]  = $signed({1'b0, hi_ch[c]}) - $signed({1'b0, lo_ch[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (sel_ready) begin
      e_valid <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_ready && sel_valid) begin
      for (int c = 0; c < 3; c++) begin
        e_prod[c] <= $signed({1'b0, num}) * diff[c];
        e_base[c] <= BASEW'(lo_ch[c]) * BASEW'(sel.span);
      end
      e_span  <= sel.span;
      e_blank <= sel.blank;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = $signed(PRODW'(e_base[c]) << F) + e_prod[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_ready) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && e_valid) begin
      for (int c = 0; c < 3; c++) begin
        f_q1[c] <= sum[c][F+QW-1:F];
      end
      f_span  <= e_span;
      f_blank <= e_blank;
    end
  end

  always_comb begin
    case (f_span)
      3'd2:    recip = RECIP_2;
      3'd3:    recip = RECIP_3;
      3'd4:    recip = RECIP_4;
      3'd5:    recip = RECIP_5;
      3'd6:    recip = RECIP_6;
      default: recip = RECIP_1;
    endcase
    for (int c = 0; c < 3; c++) begin
      prodm[c] = (QW + MW)'(f_q1[c]) * (QW + MW)'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (g_ready) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (g_ready && f_valid) begin
      for (int c = 0; c < 3; c++) begin
        g_q1[c]   <= f_q1[c];
        g_qest[c] <= prodm[c][QW+CB-1:QW];
      end
      g_span  <= f_span;
      g_blank <= f_blank;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem[c] = g_q1[c] - QW'(QW'(g_qest[c]) * QW'(g_span));
      if (rem[c] >= QW'(g_span)) begin
        quot[c] = g_qest[c] + 1'b1;
      end else begin
        quot[c] = g_qest[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (h_ready) begin
      color_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (h_ready && g_valid) begin
      for (int c = 0; c < 3; c++) begin
        h_ch[c] <= g_blank ? '0 : quot[c];
      end
    end
  end

  assign red   = h_ch[0];
  assign green = h_ch[1];
  assign blue  = h_ch[2];

endmodule

// File: hw/rtl/piecewise_color_gradient_map_top.sv
// Throughput: one position per cycle while the output is not stalled; four
// stages locate the segment and the blend weight, four more fetch the stops,
// interpolate and divide by the span. Bubbles close up under output stall, so
// input is taken while results wait, until the pipeline is full.
// Reset (synchronous, active high) empties the pipeline and returns the
// registers to mode 0, a repeat count of one and all stops black.
module piecewise_color_gradient_map_top #(
  parameter int CHANNEL_BITS       = pcgm_pkg::CHANNEL_BITS_DEF,
  parameter int POSITION_FRAC_BITS = pcgm_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pcgm_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [pcgm_pkg::DATA_BITS-1:0]       pwdata,
  output logic [pcgm_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready,
  input  logic                                 position_valid,
  output logic                                 position_stall,
  input  logic signed [POSITION_FRAC_BITS+1:0] position,
  output logic                                 color_valid,
  input  logic                                 color_stall,
  output logic [CHANNEL_BITS-1:0]              red,
  output logic [CHANNEL_BITS-1:0]              green,
  output logic [CHANNEL_BITS-1:0]              blue
);
  import pcgm_pkg::*;

  mode_t                                  mode;
  logic [REPEAT_BITS-1:0]                 repeat_count;
  logic [NUM_STOPS-1:0][2:0][CHANNEL_BITS-1:0] stops;
  logic                                   pos_ready;
  logic                                   sel_valid;
  logic                                   sel_ready;
  seg_sel_t                               sel;
  logic [POSITION_FRAC_BITS+2:0]          num;

  assign pready         = 1'b1;
  assign position_stall = !pos_ready;

  pcgm_regs #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .mode         (mode),
    .repeat_count (repeat_count),
    .stops        (stops)
  );

  pcgm_locate #(
    .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
  ) u_locate (
    .clk          (clk),
    .rst          (rst),
    .pos_valid    (position_valid),
    .pos_ready    (pos_ready),
    .position     (position),
    .mode         (mode),
    .repeat_count (repeat_count),
    .sel_valid    (sel_valid),
    .sel_ready    (sel_ready),
    .sel          (sel),
    .num          (num)
  );

  pcgm_blend #(
    .CHANNEL_BITS       (CHANNEL_BITS),
    .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
  ) u_blend (
    .clk         (clk),
    .rst         (rst),
    .sel_valid   (sel_valid),
    .sel_ready   (sel_ready),
    .sel         (sel),
    .num         (num),
    .stops       (stops),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

endmodule
